/* src/cbpg_pkg.sv */
// Shared types and constants for the color bar pattern generator.
// Holds the bar color table, the marker word and the register index codes.
// No dependencies.
package cbpg_pkg;

    typedef enum logic [2:0] {
        CFG_LINE_PAIRS    = 3'd0,
        CFG_FRAME_LINES   = 3'd1,
        CFG_INTERLACED    = 3'd2,
        CFG_MARKER_ENABLE = 3'd3,
        CFG_MARKER_LINE   = 3'd4
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned PAIRS_W    = 12;
    localparam int unsigned LINES_W    = 13;
    localparam int unsigned MARKER_W   = 12;
    localparam int unsigned WORD_W     = 32;

    localparam logic [2:0]        LAST_BAR    = 3'd7;
    localparam logic [WORD_W-1:0] MARKER_WORD = 32'hEB80EB80;

    localparam logic [7:0] BAR_Y [8] = '{8'hb4, 8'ha8, 8'h91, 8'h85,
                                         8'h3f, 8'h33, 8'h1c, 8'h10};
    localparam logic [7:0] BAR_U [8] = '{8'h80, 8'h2c, 8'h93, 8'h3f,
                                         8'hc1, 8'h61, 8'hd4, 8'h80};
    localparam logic [7:0] BAR_V [8] = '{8'h80, 8'h88, 8'h2c, 8'h34,
                                         8'hcc, 8'hd4, 8'h78, 8'h80};

    function automatic logic [WORD_W-1:0] bar_word(input logic [2:0] bar);
        bar_word = {BAR_Y[bar], BAR_U[bar], BAR_Y[bar], BAR_V[bar]};
    endfunction

endpackage

/* src/color_bar_pattern_generator_unit.sv */
// Top level of the color bar pattern generator (YCbCr 4:2:2, two pixels a word).
// Depends on cbpg_pkg for the color table, marker word and register codes.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | i_valid, o_stall, i_restart                | in
//  output    | o_valid, i_stall, o_pixel_word, o_end_of_* | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index/data | in
//
// One word per clock while not stalled: a transaction taken at one edge appears
// in the output register after that edge, and a new one can be taken every cycle.
// The output register frees up when its word is taken, so a stalled output only
// stalls the input while the register is full.
// A write to the width register starts a bar recomputation (one compare and
// subtract per cycle) during which the input is stalled.
// Reset is synchronous and active low and loads the default register values.
module color_bar_pattern_generator_unit #(
    parameter int unsigned MAX_PAIRS = 2048,
    parameter int unsigned MAX_ROWS  = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_restart,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [cbpg_pkg::WORD_W-1:0]       o_pixel_word,
    output logic                              o_end_of_line,
    output logic                              o_end_of_frame,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cbpg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbpg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned PCW = $clog2(MAX_PAIRS + 1);
    localparam int unsigned PPW = $clog2(MAX_PAIRS);
    localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
    localparam int unsigned RPW = $clog2(MAX_ROWS);
    localparam int unsigned XW  = PCW + 2;
    localparam int unsigned LW  = ((RCW > cbpg_pkg::LINES_W) ? RCW : cbpg_pkg::LINES_W) + 2;

    logic [cbpg_pkg::PAIRS_W-1:0]  r_line_pairs;
    logic [cbpg_pkg::LINES_W-1:0]  r_frame_lines;
    logic                          r_interlaced;
    logic                          r_marker_enable;
    logic [cbpg_pkg::MARKER_W-1:0] r_marker_line;

    logic [PPW-1:0] r_pair, n_pair;
    logic [RPW-1:0] r_row, n_row;
    logic [2:0]     r_bar, n_bar;
    logic [PPW:0]   r_rem, n_rem;
    logic           r_recalc;
    logic           r_valid;

    logic [cbpg_pkg::WORD_W-1:0] r_word, n_word;
    logic                        r_eol, r_eof;

    logic [PCW-1:0] eff_pairs;
    logic [RCW-1:0] eff_rows;
    logic [PCW-1:0] bar_w;
    logic           take_in;
    logic           start;
    logic [PPW-1:0] cur_pair;
    logic [RPW-1:0] cur_row;
    logic [2:0]     cur_bar;
    logic [PPW:0]   cur_rem;
    logic [2:0]     show_bar;
    logic [XW-1:0]  step_sum;
    logic [XW-1:0]  bar_w_x;
    logic [XW-1:0]  bar_w2_x;
    logic [LW-1:0]  mark_row;
    logic           marked;
    logic           eol, eof;
    logic [XW-1:0]  rc_rem_x;

    always_comb begin
        if (r_line_pairs == '0) begin
            eff_pairs = PCW'(1);
        end else if ({2'b00, r_line_pairs} > 14'(MAX_PAIRS)) begin
            eff_pairs = PCW'(MAX_PAIRS);
        end else begin
            eff_pairs = PCW'(r_line_pairs);
        end
        if (r_frame_lines == '0) begin
            eff_rows = RCW'(1);
        end else if ({1'b0, r_frame_lines} > 14'(MAX_ROWS)) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_frame_lines);
        end
    end

    assign bar_w    = eff_pairs >> 2;
    assign bar_w_x  = XW'(bar_w);
    assign bar_w2_x = XW'(bar_w) << 1;

    assign o_stall     = r_recalc | (r_valid & i_stall);
    assign take_in     = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        start    = i_restart || (PCW'(r_pair) >= eff_pairs) || (RCW'(r_row) >= eff_rows);
        cur_pair = start ? '0 : r_pair;
        cur_row  = start ? '0 : r_row;
        cur_bar  = start ? '0 : r_bar;
        cur_rem  = start ? '0 : r_rem;
        show_bar = (bar_w == '0) ? cbpg_pkg::LAST_BAR : cur_bar;

        if (r_interlaced && r_marker_line[0]) begin
            mark_row = LW'((eff_rows + RCW'(1)) >> 1) + LW'(r_marker_line >> 1);
        end else if (r_interlaced) begin
            mark_row = LW'(r_marker_line >> 1);
        end else begin
            mark_row = LW'(r_marker_line);
        end
        marked = r_marker_enable && (mark_row < LW'(eff_rows)) && (mark_row == LW'(cur_row));
        n_word = marked ? cbpg_pkg::MARKER_WORD : cbpg_pkg::bar_word(show_bar);

        eol = (PCW'(cur_pair) == eff_pairs - PCW'(1));
        eof = eol && (RCW'(cur_row) == eff_rows - RCW'(1));

        step_sum = XW'(cur_rem) + XW'(2);
        n_bar    = cur_bar;
        n_rem    = PPW'(1) == '0 ? '0 : (PPW + 1)'(step_sum);
        if (bar_w == '0) begin
            n_bar = '0;
            n_rem = '0;
        end else if (cur_bar != cbpg_pkg::LAST_BAR) begin
            if ((cur_bar < 3'd6) && (step_sum >= bar_w2_x)) begin
                n_bar = cur_bar + 3'd2;
                n_rem = (PPW + 1)'(step_sum - bar_w2_x);
            end else if (step_sum >= bar_w_x) begin
                n_bar = cur_bar + 3'd1;
                n_rem = (PPW + 1)'(step_sum - bar_w_x);
            end
        end

        if (eol) begin
            n_pair = '0;
            n_row  = eof ? '0 : cur_row + RPW'(1);
            n_bar  = '0;
            n_rem  = '0;
        end else begin
            n_pair = cur_pair + PPW'(1);
            n_row  = cur_row;
        end
    end

    assign rc_rem_x = XW'(r_rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pairs    <= cbpg_pkg::PAIRS_W'(960);
            r_frame_lines   <= cbpg_pkg::LINES_W'(1080);
            r_interlaced    <= 1'b0;
            r_marker_enable <= 1'b0;
            r_marker_line   <= '0;
            r_pair          <= '0;
            r_row           <= '0;
            r_bar           <= '0;
            r_rem           <= '0;
            r_recalc        <= 1'b0;
            r_valid         <= 1'b0;
        end else begin
            if (take_in) begin
                r_pair  <= n_pair;
                r_row   <= n_row;
                r_bar   <= n_bar;
                r_rem   <= n_rem;
                r_valid <= 1'b1;
            end else begin
                if (!i_stall) begin
                    r_valid <= 1'b0;
                end
                if (r_recalc) begin
                    if ((bar_w == '0) || (r_bar == cbpg_pkg::LAST_BAR) ||
                        (rc_rem_x < bar_w_x)) begin
                        r_recalc <= 1'b0;
                    end else begin
                        r_bar <= r_bar + 3'd1;
                        r_rem <= (PPW + 1)'(rc_rem_x - bar_w_x);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (cbpg_pkg::t_cfg_idx'(i_cfg_index))
                    cbpg_pkg::CFG_LINE_PAIRS: begin
                        r_line_pairs <= i_cfg_data[cbpg_pkg::PAIRS_W-1:0];
                        r_recalc     <= 1'b1;
                        r_bar        <= '0;
                        r_rem        <= {r_pair, 1'b0};
                    end
                    cbpg_pkg::CFG_FRAME_LINES: begin
                        r_frame_lines <= i_cfg_data[cbpg_pkg::LINES_W-1:0];
                    end
                    cbpg_pkg::CFG_INTERLACED: begin
                        r_interlaced <= i_cfg_data[0];
                    end
                    cbpg_pkg::CFG_MARKER_ENABLE: begin
                        r_marker_enable <= i_cfg_data[0];
                    end
                    cbpg_pkg::CFG_MARKER_LINE: begin
                        r_marker_line <= i_cfg_data[cbpg_pkg::MARKER_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_word <= n_word;
            r_eol  <= eol;
            r_eof  <= eof;
        end
    end

    assign o_valid        = r_valid;
    assign o_pixel_word   = r_word;
    assign o_end_of_line  = r_eol;
    assign o_end_of_frame = r_eof;

endmodule

/* src/cbpg_chk.sv */
// Port-level checker for the color bar pattern generator, bound to the top level.
// Depends on cbpg_pkg for the word width.
module cbpg_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [cbpg_pkg::WORD_W-1:0]     o_pixel_word,
    input logic                            o_end_of_line,
    input logic                            o_end_of_frame
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pixel_word)))
        else $error("Stalled output transaction changed or vanished.");

    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_end_of_frame) |-> o_end_of_line)
        else $error("End of frame without end of line.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid right after reset.");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("Accepted transaction produced no result.");

endmodule

bind color_bar_pattern_generator_unit cbpg_chk u_cbpg_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_pixel_word   (o_pixel_word),
    .o_end_of_line  (o_end_of_line),
    .o_end_of_frame (o_end_of_frame)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for color_bar_pattern_generator_unit.
// A scoreboard class predicts every pixel word from its own copy of the registers and
// frame position. Depends on cbpg_pkg and the block's RTL only.
module testbench;

    localparam int unsigned MAX_PAIRS   = 2048;
    localparam int unsigned MAX_ROWS    = 4096;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RAND_ITEMS  = 1750;
    localparam logic [31:0] WHITE_WORD  = 32'hEB80EB80;

    typedef struct packed {
        logic [31:0] word;
        logic        eol;
        logic        eof;
    } pixel_out_t;

    typedef struct {
        int unsigned pairs;
        int unsigned lines;
        bit          ilace;
        bit          marker_on;
        int unsigned mline;
    } frame_setup_t;

    class frame_scoreboard;
        logic [11:0] line_pairs;
        logic [12:0] frame_lines;
        bit          interlaced;
        bit          marker_on;
        logic [11:0] marker_line;
        int unsigned pair_pos;
        int unsigned row_pos;
        pixel_out_t  pending_words[$];
        int unsigned errors;

        function new();
            line_pairs  = 12'd960;
            frame_lines = 13'd1080;
            interlaced  = 1'b0;
            marker_on   = 1'b0;
            marker_line = '0;
            pair_pos    = 0;
            row_pos     = 0;
            errors      = 0;
        endfunction

        function void set_reg(input cbpg_pkg::t_cfg_idx idx, input logic [12:0] data);
            case (idx)
                cbpg_pkg::CFG_LINE_PAIRS:    line_pairs  = data[11:0];
                cbpg_pkg::CFG_FRAME_LINES:   frame_lines = data;
                cbpg_pkg::CFG_INTERLACED:    interlaced  = data[0];
                cbpg_pkg::CFG_MARKER_ENABLE: marker_on   = data[0];
                cbpg_pkg::CFG_MARKER_LINE:   marker_line = data[11:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] bar_color(input int unsigned bar);
            logic [23:0] yuv;
            case (bar)
                0:       yuv = 24'hb48080;
                1:       yuv = 24'ha82c88;
                2:       yuv = 24'h91932c;
                3:       yuv = 24'h853f34;
                4:       yuv = 24'h3fc1cc;
                5:       yuv = 24'h3361d4;
                6:       yuv = 24'h1cd478;
                default: yuv = 24'h108080;
            endcase
            return {yuv[23:16], yuv[15:8], yuv[23:16], yuv[7:0]};
        endfunction

        function void note_request(input bit restart);
            int unsigned pairs;
            int unsigned rows;
            int unsigned bar_w;
            int unsigned bar;
            int unsigned mrow;
            pixel_out_t  res;
            pairs = (line_pairs == 0) ? 1 : int'(line_pairs);
            if (pairs > MAX_PAIRS) pairs = MAX_PAIRS;
            rows = (frame_lines == 0) ? 1 : int'(frame_lines);
            if (rows > MAX_ROWS) rows = MAX_ROWS;
            bar_w = pairs / 4;
            if (restart || pair_pos >= pairs || row_pos >= rows) begin
                pair_pos = 0;
                row_pos  = 0;
            end
            if (bar_w == 0) begin
                bar = 7;
            end else begin
                bar = (2 * pair_pos) / bar_w;
                if (bar > 7) bar = 7;
            end
            if (!interlaced) begin
                mrow = marker_line;
            end else if (marker_line[0]) begin
                mrow = (rows + 1) / 2 + marker_line / 2;
            end else begin
                mrow = marker_line / 2;
            end
            res.word = (marker_on && mrow < rows && mrow == row_pos) ? WHITE_WORD
                                                                    : bar_color(bar);
            res.eol = (pair_pos == pairs - 1);
            res.eof = res.eol && (row_pos == rows - 1);
            pending_words.push_back(res);
            if (res.eol) begin
                pair_pos = 0;
                row_pos  = res.eof ? 0 : row_pos + 1;
            end else begin
                pair_pos++;
            end
        endfunction

        function void check_word(input logic [31:0] word, input logic eol, input logic eof);
            pixel_out_t want;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected word %h eol %b eof %b", word, eol, eof);
                return;
            end
            want = pending_words.pop_front();
            if (word !== want.word || eol !== want.eol || eof !== want.eof) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected %h eol %b eof %b, got %h eol %b eof %b",
                             want.word, want.eol, want.eof, word, eol, eof);
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic                            i_restart;
    logic                            o_valid;
    logic                            i_stall;
    logic [cbpg_pkg::WORD_W-1:0]     o_pixel_word;
    logic                            o_end_of_line;
    logic                            o_end_of_frame;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [cbpg_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [cbpg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    frame_scoreboard bar_model;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     cycle_count;

    color_bar_pattern_generator_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_word   (o_pixel_word),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            bar_model.check_word(o_pixel_word, o_end_of_line, o_end_of_frame);
    end

    task automatic send_item(input bit restart);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid   <= 1'b0;
            i_restart <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall);
        bar_model.note_request(restart);
    endtask

    task automatic drain_words();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (bar_model.pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input cbpg_pkg::t_cfg_idx idx, input logic [12:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        bar_model.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setup(input frame_setup_t s);
        logic [11:0] junk;
        drain_words();
        repeat (12) @(posedge i_clk);
        junk = ($urandom_range(3) == 0) ? 12'($urandom) : 12'd0;
        cfg_write(cbpg_pkg::CFG_LINE_PAIRS, 13'(s.pairs));
        cfg_write(cbpg_pkg::CFG_FRAME_LINES, 13'(s.lines));
        cfg_write(cbpg_pkg::CFG_INTERLACED, {junk, s.ilace});
        cfg_write(cbpg_pkg::CFG_MARKER_ENABLE, {junk, s.marker_on});
        cfg_write(cbpg_pkg::CFG_MARKER_LINE, 13'(s.mline) | {junk[0], 12'd0});
    endtask

    function automatic frame_setup_t random_setup();
        frame_setup_t s;
        int unsigned  pick;
        pick = $urandom_range(99);
        if (pick < 10)      s.pairs = $urandom_range(0, 7);
        else if (pick < 80) s.pairs = $urandom_range(8, 40);
        else if (pick < 90) s.pairs = $urandom_range(41, MAX_PAIRS);
        else                s.pairs = 13'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)      s.lines = $urandom_range(0, 1);
        else if (pick < 80) s.lines = $urandom_range(2, 6);
        else if (pick < 90) s.lines = $urandom_range(7, MAX_ROWS);
        else                s.lines = 13'($urandom);
        s.ilace     = 1'($urandom);
        s.marker_on = ($urandom_range(3) != 0);
        if ($urandom_range(4) == 0) s.mline = 12'($urandom);
        else s.mline = $urandom_range(0, 2 * (s.lines > 16 ? 16 : s.lines) + 3);
        return s;
    endfunction

    initial begin
        int unsigned rand_sent;
        int unsigned n;
        bar_model     = new();
        cycle_count   = 0;
        send_idle_pct = 16;
        recv_idle_pct = 60;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_restart     = 1'b0;
        i_stall       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        apply_setup('{pairs: 0, lines: 0, ilace: 0, marker_on: 0, mline: 0});
        repeat (2) send_item(1'b0);
        apply_setup('{pairs: 3, lines: 2, ilace: 0, marker_on: 1, mline: 1});
        repeat (6) send_item(1'b0);
        apply_setup('{pairs: 5, lines: 2, ilace: 1, marker_on: 1, mline: 1});
        repeat (10) send_item(1'b0);
        apply_setup('{pairs: 4095, lines: 8191, ilace: 1, marker_on: 1, mline: 4094});
        send_item(1'b0);

        rand_sent = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (rand_sent < RAND_ITEMS / 3) begin
                send_idle_pct = 16;
                recv_idle_pct = 60;
            end else if (rand_sent < 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 16;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setup(random_setup());
            n = $urandom_range(20, 80);
            repeat (n) send_item($urandom_range(99) < 3);
            rand_sent += n;
        end

        drain_words();
        repeat (20) @(posedge i_clk);
        if (bar_model.errors == 0 && bar_model.pending_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* files.f */
src/cbpg_pkg.sv
src/color_bar_pattern_generator_unit.sv
src/cbpg_chk.sv
tb/testbench.sv
